FILE: design/rrts_pkg.sv
package rrts_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int OP_W      = 3;
  localparam int TICKS_W   = 32;
  localparam int SLICE_W   = 8;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd16;

  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } slot_state_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_SLEEP  = 3'd1,
    OP_BLOCK  = 3'd2,
    OP_WAKE   = 3'd3,
    OP_EXIT   = 3'd4,
    OP_CREATE = 3'd5
  } op_t;

  typedef struct packed {
    slot_state_t        st;
    logic [TICKS_W-1:0] sleep;
    logic               wf;
    logic [SLICE_W-1:0] used;
  } slot_data_t;

  // broadcast from the top to every cell
  typedef struct packed {
    logic               fire;
    logic               do_tick;
    logic               mark_sleep;
    logic               mark_block;
    logic               mark_exit;
    logic               wake;
    logic               create;
    logic [TICKS_W-1:0] ticks;
    logic [SLOT_W-1:0]  target;
    logic [SLOT_W-1:0]  cur;
    slot_data_t         cur_data;
  } sched_req_t;

  typedef struct packed {
    logic              keep;
    logic [SLOT_W-1:0] pick;
  } sched_dec_t;

  // ripple signals handed from one cell to the next
  typedef struct packed {
    logic hi;
    logic lo;
    logic dead;
  } chain_t;

  typedef struct packed {
    logic hi_here;
    logic lo_here;
    logic dead_here;
    logic woke;
  } cell_flags_t;

endpackage

FILE: design/rrts_in_if.sv
interface rrts_in_if import rrts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [TICKS_W-1:0] sleep_ticks;
  logic [SLOT_W-1:0]  target_slot;

  modport source (output valid, output operation, output sleep_ticks, output target_slot,
                  input ready);
  modport sink (input valid, input operation, input sleep_ticks, input target_slot,
                output ready);
endinterface

FILE: design/rrts_out_if.sv
interface rrts_out_if import rrts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] running_slot;
  logic              switched;
  logic [SLOT_W-1:0] new_slot;
  logic              status;

  modport source (output valid, output running_slot, output switched, output new_slot,
                  output status, input ready);
  modport sink (input valid, input running_slot, input switched, input new_slot,
                input status, output ready);
endinterface

FILE: design/rrts_cell.sv
module rrts_cell import rrts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] idx,
  input  sched_req_t        req,
  input  sched_dec_t        dec,
  input  slot_data_t        cur_in,
  output slot_data_t        cur_out,
  input  chain_t            chain_in,
  output chain_t            chain_out,
  output cell_flags_t       flags
);

  slot_state_t        st_r, st_nxt;
  logic [TICKS_W-1:0] sleep_r, sleep_nxt;
  logic               wf_r, wf_nxt;
  logic [SLICE_W-1:0] used_r, used_nxt;

  logic is_cur;
  logic expire;
  logic cand;
  logic after_cur;
  logic before_cur;
  logic is_dead;

  assign is_cur     = (idx == req.cur);
  assign after_cur  = (idx > req.cur);
  assign before_cur = (idx < req.cur);
  assign is_dead    = (st_r == ST_DEAD);

  // current slot's contents ride down the chain to the top
  assign cur_out = is_cur ? slot_data_t'{st: st_r, sleep: sleep_r, wf: wf_r, used: used_r}
                          : cur_in;

  // countdown reaching zero on this tick makes the slot a candidate already
  assign expire = !is_cur && (st_r == ST_BLOCKED) && !wf_r && (sleep_r <= TICKS_W'(1));
  assign cand   = (idx != '0) && !is_cur && ((st_r == ST_RUNNABLE) || expire);

  assign chain_out.hi   = chain_in.hi || (cand && after_cur);
  assign chain_out.lo   = chain_in.lo || (cand && before_cur);
  assign chain_out.dead = chain_in.dead || is_dead;

  assign flags.hi_here   = cand && after_cur && !chain_in.hi;
  assign flags.lo_here   = cand && before_cur && !chain_in.lo;
  assign flags.dead_here = is_dead && !chain_in.dead;
  assign flags.woke      = req.wake && (idx == req.target) && (st_r == ST_BLOCKED);

  always_comb begin
    st_nxt    = st_r;
    sleep_nxt = sleep_r;
    wf_nxt    = wf_r;
    used_nxt  = used_r;
    if (req.fire) begin
      if (is_cur && req.mark_sleep) begin
        st_nxt    = ST_BLOCKED;
        sleep_nxt = req.ticks;
        wf_nxt    = 1'b0;
      end
      if (is_cur && req.mark_block) begin
        st_nxt = ST_BLOCKED;
        wf_nxt = 1'b1;
      end
      if (is_cur && req.mark_exit) begin
        st_nxt = ST_DEAD;
      end
      if (flags.woke) begin
        st_nxt    = ST_RUNNABLE;
        sleep_nxt = '0;
        wf_nxt    = 1'b0;
      end
      if (req.create && flags.dead_here) begin
        st_nxt    = ST_RUNNABLE;
        sleep_nxt = req.cur_data.sleep;
        wf_nxt    = req.cur_data.wf;
        used_nxt  = req.cur_data.used;
      end
      if (req.do_tick) begin
        if (!is_cur && (st_nxt == ST_BLOCKED) && !wf_nxt) begin
          if (sleep_nxt != '0) begin
            sleep_nxt = sleep_nxt - TICKS_W'(1);
          end
          if (sleep_nxt == '0) begin
            st_nxt = ST_RUNNABLE;
          end
        end
        if (is_cur) begin
          if (dec.keep) begin
            used_nxt = used_nxt + SLICE_W'(1);
          end else if (st_nxt == ST_RUNNING) begin
            st_nxt   = ST_RUNNABLE;
            used_nxt = '0;
          end
        end
        if (!dec.keep && (idx == dec.pick)) begin
          st_nxt   = ST_RUNNING;
          used_nxt = SLICE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= (idx == '0) ? ST_RUNNING : ST_DEAD;
      sleep_r <= '0;
      wf_r    <= 1'b0;
      used_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      sleep_r <= sleep_nxt;
      wf_r    <= wf_nxt;
      used_r  <= used_nxt;
    end
  end

endmodule

FILE: design/round_robin_tick_scheduler.sv
// Round-robin time-slice task scheduler over a row of task slot cells.
// in_ch carries one operation word (tick, sleep, block, wake, exit, create)
// with its sleep length and wake target. out_ch returns one result word per
// operation: the slot running afterwards, whether it was reselected, the slot
// claimed by create and a reject status.
// The result word is registered and shows on out_ch in the cycle after the
// operation word is taken. Throughput: one word per cycle while out_ch.ready
// allows it; the countdowns run in parallel in the cells and the next slot is
// found by a combinational ripple chain through the row of cells.
// slice_length is written through cfg_we/cfg_wdata; the user writes it only
// while the block is idle, which the block does not enforce. Reset: slot 0
// running, all other slots dead, slice_length 16, no result pending.
// Stall: while a result waits on out_ch with out_ch.ready low, in_ch.ready
// drops; the waiting result holds until it is taken.
module round_robin_tick_scheduler import rrts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rrts_in_if.sink            in_ch,
  rrts_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [SLICE_W-1:0] cfg_wdata
);

  logic [SLICE_W-1:0] slice_len_r, slice_len_nxt;
  logic [SLOT_W-1:0]  cur_r, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]  out_running_r, out_running_nxt;
  logic               out_switched_r, out_switched_nxt;
  logic [SLOT_W-1:0]  out_new_r, out_new_nxt;
  logic               out_status_r, out_status_nxt;

  logic        fire;
  logic        plain_tick;
  sched_req_t  req;
  sched_dec_t  dec;
  slot_data_t  cur_chain [NUM_SLOTS+1];
  chain_t      chain     [NUM_SLOTS+1];
  cell_flags_t flags     [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] hi_vec, lo_vec, dead_vec, woke_vec;
  logic [SLOT_W-1:0]    hi_idx, lo_idx, dead_idx;
  logic                 cur_stays;

  assign fire        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;

  always_comb begin
    req            = '0;
    req.fire       = fire;
    req.ticks      = in_ch.sleep_ticks;
    req.target     = in_ch.target_slot;
    req.cur        = cur_r;
    req.cur_data   = cur_chain[NUM_SLOTS];
    plain_tick     = 1'b0;
    case (in_ch.operation)
      OP_TICK: begin
        req.do_tick = 1'b1;
        plain_tick  = 1'b1;
      end
      OP_SLEEP: begin
        // zero-length sleep leaves everything as it is
        req.mark_sleep = (in_ch.sleep_ticks != '0);
        req.do_tick    = (in_ch.sleep_ticks != '0);
      end
      OP_BLOCK: begin
        req.mark_block = 1'b1;
        req.do_tick    = 1'b1;
      end
      OP_WAKE: begin
        req.wake = 1'b1;
      end
      OP_EXIT: begin
        req.mark_exit = 1'b1;
        req.do_tick   = 1'b1;
      end
      OP_CREATE: begin
        req.create = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cur_chain[0] = '0;
  assign chain[0]     = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    rrts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (SLOT_W'(i)),
      .req       (req),
      .dec       (dec),
      .cur_in    (cur_chain[i]),
      .cur_out   (cur_chain[i+1]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .flags     (flags[i])
    );
    assign hi_vec[i]   = flags[i].hi_here;
    assign lo_vec[i]   = flags[i].lo_here;
    assign dead_vec[i] = flags[i].dead_here;
    assign woke_vec[i] = flags[i].woke;
  end

  // at most one flag of each kind is set, so or-ing the indexes encodes it
  always_comb begin
    hi_idx   = '0;
    lo_idx   = '0;
    dead_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hi_vec[i]) hi_idx = hi_idx | SLOT_W'(i);
      if (lo_vec[i]) lo_idx = lo_idx | SLOT_W'(i);
      if (dead_vec[i]) dead_idx = dead_idx | SLOT_W'(i);
    end
  end

  // only a plain tick can leave the current slot running or runnable
  assign cur_stays = plain_tick && ((req.cur_data.st == ST_RUNNING) ||
                                    (req.cur_data.st == ST_RUNNABLE));

  always_comb begin
    // sleep, block and exit take the current slot out of running first
    dec.keep = plain_tick && (req.cur_data.st == ST_RUNNING) &&
               (req.cur_data.used < slice_len_r);
    if (chain[NUM_SLOTS].hi) begin
      dec.pick = hi_idx;
    end else if (chain[NUM_SLOTS].lo) begin
      dec.pick = lo_idx;
    end else if (cur_stays) begin
      dec.pick = cur_r;
    end else begin
      dec.pick = '0;
    end
  end

  always_comb begin
    slice_len_nxt    = cfg_we ? cfg_wdata : slice_len_r;
    cur_nxt          = cur_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_running_nxt  = out_running_r;
    out_switched_nxt = out_switched_r;
    out_new_nxt      = out_new_r;
    out_status_nxt   = out_status_r;
    if (fire) begin
      if (req.do_tick && !dec.keep) begin
        cur_nxt = dec.pick;
      end
      out_valid_nxt    = 1'b1;
      out_running_nxt  = (req.do_tick && !dec.keep) ? dec.pick : cur_r;
      out_switched_nxt = req.do_tick && !dec.keep;
      out_new_nxt      = (req.create && chain[NUM_SLOTS].dead) ? dead_idx : '0;
      out_status_nxt   = (req.create && !chain[NUM_SLOTS].dead) ||
                         (req.wake && (woke_vec == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_len_r <= SLICE_RESET;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slice_len_r <= slice_len_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_running_r  <= out_running_nxt;
    out_switched_r <= out_switched_nxt;
    out_new_r      <= out_new_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.running_slot = out_running_r;
  assign out_ch.switched     = out_switched_r;
  assign out_ch.new_slot     = out_new_r;
  assign out_ch.status       = out_status_r;

`ifndef ASSERT_OFF
  // the slot named current is always the one in the running state
  a_cur_running: assert property (@(posedge clk) disable iff (!rst_n)
    req.cur_data.st == ST_RUNNING)
    else $error("current slot not running");

  a_hi_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hi_vec) && $onehot0(lo_vec) && $onehot0(dead_vec))
    else $error("round-robin chain flagged more than one slot");

  a_no_tick_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !req.do_tick |=> !out_ch.switched && (out_ch.running_slot == $past(cur_r)))
    else $error("non-tick operation reselected the running slot");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_valid_r && !out_ch.ready)
    else $error("input stalled without a waiting result");
`endif

endmodule

FILE: dv/tb_round_robin_tick_scheduler.sv
module tb_round_robin_tick_scheduler;
  import rrts_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_PHASES = 6;
  localparam int WORDS_PER_PHASE = 125;

  // operation codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [OP_W-1:0]    operation;
    logic [TICKS_W-1:0] sleep_ticks;
    logic [SLOT_W-1:0]  target_slot;
  } sched_word_t;

  typedef struct {
    logic [SLOT_W-1:0] running_slot;
    logic              switched;
    logic [SLOT_W-1:0] new_slot;
    logic              status;
  } sched_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [SLICE_W-1:0] cfg_wdata;

  rrts_in_if  in_ch();
  rrts_out_if out_ch();

  round_robin_tick_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // scheduler image kept by the testbench
  slot_state_t        slot_st      [NUM_SLOTS];
  logic [TICKS_W-1:0] nap_left     [NUM_SLOTS];
  logic               nap_forever  [NUM_SLOTS];
  logic [SLICE_W-1:0] used_units   [NUM_SLOTS];
  logic [SLOT_W-1:0]  cur_slot;
  logic [SLICE_W-1:0] slice_len;

  sched_word_t   word_q[$];
  sched_result_t sched_result_q[$];
  sched_word_t   on_bus;
  logic          burst_mode;
  int            err_count = 0;
  int            send_gap;
  int            stall_left;
  int            idle_cycles = 0;

  function automatic void reset_image();
    int k;
    for (k = 0; k < NUM_SLOTS; k++) begin
      slot_st[k]     = ST_DEAD;
      nap_left[k]    = '0;
      nap_forever[k] = 1'b0;
      used_units[k]  = '0;
    end
    slot_st[0] = ST_RUNNING;
    cur_slot   = '0;
    slice_len  = SLICE_RESET;
  endfunction

  // returns 1 when the reselection path ran
  function automatic logic advance_tick();
    int   cur, s, k, pick;
    logic found;
    cur   = int'(cur_slot);
    found = 1'b0;
    for (k = 0; k < NUM_SLOTS; k++) begin
      if (k != cur && slot_st[k] == ST_BLOCKED && !nap_forever[k]) begin
        if (nap_left[k] != '0) nap_left[k] = nap_left[k] - 1'b1;
        if (nap_left[k] == '0) slot_st[k] = ST_RUNNABLE;
      end
    end
    if (slot_st[cur] == ST_RUNNING && used_units[cur] < slice_len) begin
      used_units[cur] = used_units[cur] + 1'b1;
      return 1'b0;
    end
    if (slot_st[cur] == ST_RUNNING) begin
      slot_st[cur]    = ST_RUNNABLE;
      used_units[cur] = '0;
    end
    pick = cur;
    // round-robin search after the current slot, idle slot 0 never picked here
    for (k = 1; k < NUM_SLOTS && !found; k++) begin
      s = (cur + k) % NUM_SLOTS;
      if (s != 0 && slot_st[s] == ST_RUNNABLE) begin
        pick  = s;
        found = 1'b1;
      end
    end
    if (!found && slot_st[cur] != ST_RUNNABLE) pick = 0;
    cur_slot         = SLOT_W'(pick);
    slot_st[pick]    = ST_RUNNING;
    used_units[pick] = SLICE_W'(1);
    return 1'b1;
  endfunction

  function automatic sched_result_t predict_schedule(sched_word_t w);
    sched_result_t r;
    int            cur, k;
    logic          claimed;
    cur        = int'(cur_slot);
    r.switched = 1'b0;
    r.new_slot = '0;
    r.status   = 1'b0;
    claimed    = 1'b0;
    case (w.operation)
      OP_TICK: r.switched = advance_tick();
      OP_SLEEP: begin
        if (w.sleep_ticks != '0) begin
          slot_st[cur]     = ST_BLOCKED;
          nap_left[cur]    = w.sleep_ticks;
          nap_forever[cur] = 1'b0;
          r.switched       = advance_tick();
        end
      end
      OP_BLOCK: begin
        slot_st[cur]     = ST_BLOCKED;
        nap_forever[cur] = 1'b1;
        r.switched       = advance_tick();
      end
      OP_WAKE: begin
        if (int'(w.target_slot) < NUM_SLOTS && slot_st[w.target_slot] == ST_BLOCKED) begin
          slot_st[w.target_slot]     = ST_RUNNABLE;
          nap_left[w.target_slot]    = '0;
          nap_forever[w.target_slot] = 1'b0;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_EXIT: begin
        slot_st[cur] = ST_DEAD;
        r.switched   = advance_tick();
      end
      OP_CREATE: begin
        r.status = 1'b1;
        for (k = 0; k < NUM_SLOTS && !claimed; k++) begin
          if (slot_st[k] == ST_DEAD) begin
            slot_st[k]     = ST_RUNNABLE;
            nap_left[k]    = nap_left[cur];
            nap_forever[k] = nap_forever[cur];
            used_units[k]  = used_units[cur];
            r.new_slot     = SLOT_W'(k);
            r.status       = 1'b0;
            claimed        = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.running_slot = cur_slot;
    return r;
  endfunction

  function automatic void push_word(logic [OP_W-1:0] op, logic [TICKS_W-1:0] ticks,
                                    logic [SLOT_W-1:0] target);
    sched_word_t w;
    w.operation   = op;
    w.sleep_ticks = ticks;
    w.target_slot = target;
    word_q.push_back(w);
  endfunction

  function automatic sched_word_t random_word(bit exit_heavy);
    sched_word_t w;
    int          r;
    r             = $urandom_range(0, 99);
    w.target_slot = SLOT_W'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0:       w.sleep_ticks = '0;
      1:       w.sleep_ticks = '1;
      2:       w.sleep_ticks = $urandom();
      default: w.sleep_ticks = TICKS_W'($urandom_range(1, 12));
    endcase
    if (r < 30)                       w.operation = OP_TICK;
    else if (r < 45)                  w.operation = OP_SLEEP;
    else if (r < 53)                  w.operation = OP_BLOCK;
    else if (r < 68)                  w.operation = OP_WAKE;
    else if (r < (exit_heavy ? 88 : 76)) w.operation = OP_EXIT;
    else if (r < 95)                  w.operation = OP_CREATE;
    else                              w.operation = $urandom_range(0, 1) ? OP_SPARE_HI
                                                                         : OP_SPARE_LO;
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.operation   <= '0;
      in_ch.sleep_ticks <= '0;
      in_ch.target_slot <= '0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sched_result_q.push_back(predict_schedule(on_bus));
        send_gap = burst_mode ? 0 : $urandom_range(0, 14);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (word_q.size() != 0) begin
          on_bus = word_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.operation   <= on_bus.operation;
          in_ch.sleep_ticks <= on_bus.sleep_ticks;
          in_ch.target_slot <= on_bus.target_slot;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (sched_result_q.size() == 0) begin
          $error("result word with no prediction pending");
          err_count++;
        end else begin
          want = sched_result_q.pop_front();
          if (out_ch.running_slot !== want.running_slot) begin
            $error("running_slot: expected %0d, got %0d", want.running_slot,
                   out_ch.running_slot);
            err_count++;
          end
          if (out_ch.switched !== want.switched) begin
            $error("switched: expected %0d, got %0d", want.switched, out_ch.switched);
            err_count++;
          end
          if (out_ch.new_slot !== want.new_slot) begin
            $error("new_slot: expected %0d, got %0d", want.new_slot, out_ch.new_slot);
            err_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            err_count++;
          end
        end
        stall_left = burst_mode ? 0 : $urandom_range(0, 14);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_drained();
    while (word_q.size() != 0 || in_ch.valid || sched_result_q.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_slice(logic [SLICE_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    slice_len = value;
  endtask

  initial begin
    int                 phase, n;
    logic [SLICE_W-1:0] slice_plan [RAND_PHASES];
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = '0;
    in_ch.sleep_ticks = '0;
    in_ch.target_slot = '0;
    out_ch.ready      = 1'b0;
    burst_mode        = 1'b0;
    reset_image();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset slice length: zero sleep, spare code, rejects, fill every slot
    push_word(OP_TICK, '0, '0);
    push_word(OP_SLEEP, '0, '0);
    push_word(OP_SPARE_HI, '1, '1);
    push_word(OP_WAKE, '0, SLOT_W'(5));
    for (n = 0; n < NUM_SLOTS; n++) push_word(OP_CREATE, '0, '0);
    wait_drained();

    // slice of one: preempt on every tick
    write_slice(SLICE_W'(1));
    push_word(OP_TICK, '0, '0);
    push_word(OP_SLEEP, TICKS_W'(1), '0);
    push_word(OP_TICK, '0, '0);
    push_word(OP_BLOCK, '0, '0);
    push_word(OP_SLEEP, '1, '0);
    push_word(OP_WAKE, '0, SLOT_W'(3));
    push_word(OP_WAKE, '0, SLOT_W'(0));
    push_word(OP_EXIT, '0, '0);
    push_word(OP_CREATE, '0, '0);
    // exit everything so the idle fallback runs on a dead slot 0
    for (n = 0; n < 4; n++) push_word(OP_EXIT, '0, '0);
    wait_drained();

    // a long slice followed by a zero slice lowers it below the used count
    slice_plan[0] = SLICE_W'(3);
    slice_plan[1] = '1;
    slice_plan[2] = '0;
    slice_plan[3] = SLICE_W'($urandom_range(1, 255));
    slice_plan[4] = SLICE_W'(1);
    slice_plan[5] = SLICE_W'(2);
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      write_slice(slice_plan[phase]);
      burst_mode = (phase == 3) || ($urandom_range(0, 3) == 0);
      for (n = 0; n < WORDS_PER_PHASE; n++) word_q.push_back(random_word(phase == 4));
      wait_drained();
    end

    repeat (4) @(negedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
